>>> hdl/qdrf_pkg.sv
`timescale 1ns / 1ps
// Shared widths, payload structs and verdict codes for the quadrilateral
// diagonal ratio filter. No dependencies; every other file uses this package.
package qdrf_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIFF_W     = COORD_BITS + 1;   // signed corner difference
    localparam int PROD_W     = 2 * DIFF_W;       // signed product of two differences
    localparam int DET_W      = PROD_W + 1;       // determinant and numerators
    localparam int RAT_W      = DET_W + 1;        // ratio numerator and denominator
    localparam int MAG_W      = RAT_W - 1;        // magnitude of a positive ratio term
    localparam int CFG_W      = 16;
    localparam int FRAC_BITS  = 8;
    localparam int CMP_W      = MAG_W + CFG_W;    // width of both sides of the compare
    localparam int PIPE_DEPTH = 8;

    localparam logic [CFG_W-1:0] MAX_RATIO_RESET = 16'd410;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_PARALLEL = 2'd1;
    localparam logic [1:0] VERDICT_FIRST    = 2'd2;
    localparam logic [1:0] VERDICT_SECOND   = 2'd3;

    typedef logic [COORD_BITS-1:0]   t_coord;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [DET_W-1:0]  t_det;
    typedef logic signed [RAT_W-1:0]  t_rat;
    typedef logic [MAG_W-1:0]         t_mag;
    typedef logic [CMP_W-1:0]         t_cmp;

    typedef struct packed {
        t_coord top_left_x;
        t_coord top_left_y;
        t_coord top_right_x;
        t_coord top_right_y;
        t_coord bottom_right_x;
        t_coord bottom_right_y;
        t_coord bottom_left_x;
        t_coord bottom_left_y;
    } t_quad_in;

    typedef struct packed {
        logic       accepted;
        logic [1:0] verdict;
    } t_quad_out;

    // Load enables for the three register stages of a ratio unit.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_rc_en;

    // Operands of the final ratio compare, as left by a ratio unit.
    typedef struct packed {
        logic den_zero;
        logic num_neg;
        t_cmp lhs;
        t_cmp rhs;
    } t_rc_res;

endpackage

>>> hdl/qdrf_ratio_unit.sv
`timescale 1ns / 1ps
// Three-stage ratio unit: turns a split fraction t/d into compare operands
// against the configured maximum ratio. Depends on qdrf_pkg.
module qdrf_ratio_unit (
    input  logic                        i_clk,
    input  qdrf_pkg::t_rc_en            i_en,
    input  qdrf_pkg::t_det              i_t,
    input  qdrf_pkg::t_det              i_d,
    input  logic [qdrf_pkg::CFG_W-1:0]  i_max_ratio,
    output qdrf_pkg::t_rc_res           o_res
);

    qdrf_pkg::t_rat r_num1;
    qdrf_pkg::t_rat r_den1;
    qdrf_pkg::t_rat n_num1;
    qdrf_pkg::t_rat n_den1;
    qdrf_pkg::t_mag r_num2;
    qdrf_pkg::t_mag r_den2;
    logic           r_zero2;
    logic           r_neg2;
    qdrf_pkg::t_rc_res r_res3;

    qdrf_pkg::t_rat ext_t;
    qdrf_pkg::t_rat ext_d;
    qdrf_pkg::t_rat d_minus_t;

    // Pick t/(d-t) when t is past the midpoint, else (d-t)/t.
    always_comb begin
        ext_t     = qdrf_pkg::t_rat'(i_t);
        ext_d     = qdrf_pkg::t_rat'(i_d);
        d_minus_t = ext_d - ext_t;
        if ((ext_t + ext_t) > ext_d) begin
            n_num1 = ext_t;
            n_den1 = d_minus_t;
        end else begin
            n_num1 = d_minus_t;
            n_den1 = ext_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_num1 <= n_num1;
            r_den1 <= n_den1;
        end
    end

    // Make the denominator positive, keeping the sign of the quotient.
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_zero2 <= (r_den1 == '0);
            if (r_den1 < 0) begin
                r_neg2 <= (r_num1 > 0);
                r_num2 <= qdrf_pkg::t_mag'(r_num1 < 0 ? -r_num1 : r_num1);
                r_den2 <= qdrf_pkg::t_mag'(-r_den1);
            end else begin
                r_neg2 <= (r_num1 < 0);
                r_num2 <= qdrf_pkg::t_mag'(r_num1 < 0 ? -r_num1 : r_num1);
                r_den2 <= qdrf_pkg::t_mag'(r_den1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_res3.den_zero <= r_zero2;
            r_res3.num_neg  <= r_neg2;
            r_res3.lhs      <= qdrf_pkg::t_cmp'(r_num2) << qdrf_pkg::FRAC_BITS;
            r_res3.rhs      <= qdrf_pkg::t_cmp'(i_max_ratio) * qdrf_pkg::t_cmp'(r_den2);
        end
    end

    assign o_res = r_res3;

endmodule

>>> hdl/quad_diagonal_ratio_filter_core.sv
`timescale 1ns / 1ps
// Eight register stages; a result passes through every stage after its input
// transfer and leaves from the stage 8 output register.
// Throughput: one quadrilateral per cycle unless stalled; each of the eight stages
// holds one item and a stalled stage lets bubbles in the stages before it close up.
// Reset (synchronous, active low) empties the pipeline and sets max_ratio
// to 410 (about 1.6 in UQ8.8). Depends on qdrf_pkg and qdrf_ratio_unit.
module quad_diagonal_ratio_filter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Quadrilateral input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  qdrf_pkg::t_quad_in          i_in_data,
    // Verdict output channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output qdrf_pkg::t_quad_out         o_out_data,
    // Configuration: the max_ratio register.
    input  logic                        i_cfg_wr_en,
    input  logic [qdrf_pkg::CFG_W-1:0]  i_cfg_wr_data
);

    // Stage map:
    //   1: corner differences A = BR - TL, B = TR - BL, C = TR - TL
    //   2: the six cross products
    //   3: determinant D and numerators M, N
    //   4: sign normalization so that D > 0, plus the D == 0 flag
    //   5-7: two ratio units, one for M/D and one for N/D
    //   8: the final compares and the verdict, held as the output register

    logic [qdrf_pkg::CFG_W-1:0] r_max_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ratio <= qdrf_pkg::MAX_RATIO_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_ratio <= i_cfg_wr_data;
        end
    end

    // Each stage loads when it is empty or the stage after it is moving.
    // The last stage moves when its result transfer completes.
    logic [qdrf_pkg::PIPE_DEPTH:1] r_vld;
    logic [qdrf_pkg::PIPE_DEPTH:1] en;

    always_comb begin
        en[qdrf_pkg::PIPE_DEPTH] = !r_vld[qdrf_pkg::PIPE_DEPTH] || !i_out_stall;
        for (int k = qdrf_pkg::PIPE_DEPTH - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= qdrf_pkg::PIPE_DEPTH; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !en[1];
    assign o_out_valid = r_vld[qdrf_pkg::PIPE_DEPTH];

    // Stage 1: differences of zero-extended coordinates.
    qdrf_pkg::t_diff r_ax, r_ay, r_bx, r_by, r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_ax <= $signed({1'b0, i_in_data.bottom_right_x}) -
                    $signed({1'b0, i_in_data.top_left_x});
            r_ay <= $signed({1'b0, i_in_data.bottom_right_y}) -
                    $signed({1'b0, i_in_data.top_left_y});
            r_bx <= $signed({1'b0, i_in_data.top_right_x}) -
                    $signed({1'b0, i_in_data.bottom_left_x});
            r_by <= $signed({1'b0, i_in_data.top_right_y}) -
                    $signed({1'b0, i_in_data.bottom_left_y});
            r_cx <= $signed({1'b0, i_in_data.top_right_x}) -
                    $signed({1'b0, i_in_data.top_left_x});
            r_cy <= $signed({1'b0, i_in_data.top_right_y}) -
                    $signed({1'b0, i_in_data.top_left_y});
        end
    end

    // Stage 2: the products for Cramer's rule on m*A + n*B = C.
    qdrf_pkg::t_prod r_ax_by, r_bx_ay, r_cx_by, r_bx_cy, r_ax_cy, r_cx_ay;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_ax_by <= qdrf_pkg::t_prod'(r_ax * r_by);
            r_bx_ay <= qdrf_pkg::t_prod'(r_bx * r_ay);
            r_cx_by <= qdrf_pkg::t_prod'(r_cx * r_by);
            r_bx_cy <= qdrf_pkg::t_prod'(r_bx * r_cy);
            r_ax_cy <= qdrf_pkg::t_prod'(r_ax * r_cy);
            r_cx_ay <= qdrf_pkg::t_prod'(r_cx * r_ay);
        end
    end

    // Stage 3: determinant and the two numerators.
    qdrf_pkg::t_det r_det3, r_m3, r_n3;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_det3 <= qdrf_pkg::t_det'(r_ax_by) - qdrf_pkg::t_det'(r_bx_ay);
            r_m3   <= qdrf_pkg::t_det'(r_cx_by) - qdrf_pkg::t_det'(r_bx_cy);
            r_n3   <= qdrf_pkg::t_det'(r_ax_cy) - qdrf_pkg::t_det'(r_cx_ay);
        end
    end

    // Stage 4: flip all three signs when the determinant is negative, so the
    // split fractions become M/D and N/D with D positive. The values stay far
    // inside the determinant width, so negation cannot overflow.
    qdrf_pkg::t_det r_det4, r_m4, r_n4;
    logic           r_dz4;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_dz4 <= (r_det3 == '0);
            if (r_det3 < 0) begin
                r_det4 <= -r_det3;
                r_m4   <= -r_m3;
                r_n4   <= -r_n3;
            end else begin
                r_det4 <= r_det3;
                r_m4   <= r_m3;
                r_n4   <= r_n3;
            end
        end
    end

    // Stages 5 to 7: the ratio units, with the parallel flag riding alongside.
    qdrf_pkg::t_rc_en  rc_en;
    qdrf_pkg::t_rc_res res_m;
    qdrf_pkg::t_rc_res res_n;
    logic              r_dz5, r_dz6, r_dz7;

    assign rc_en.s1 = en[5];
    assign rc_en.s2 = en[6];
    assign rc_en.s3 = en[7];

    qdrf_ratio_unit u_ratio_m (
        .i_clk       (i_clk),
        .i_en        (rc_en),
        .i_t         (r_m4),
        .i_d         (r_det4),
        .i_max_ratio (r_max_ratio),
        .o_res       (res_m)
    );

    qdrf_ratio_unit u_ratio_n (
        .i_clk       (i_clk),
        .i_en        (rc_en),
        .i_t         (r_n4),
        .i_d         (r_det4),
        .i_max_ratio (r_max_ratio),
        .o_res       (res_n)
    );

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_dz5 <= r_dz4;
        end
        if (en[6]) begin
            r_dz6 <= r_dz5;
        end
        if (en[7]) begin
            r_dz7 <= r_dz6;
        end
    end

    // Stage 8: a zero denominator counts as an infinite ratio, and a negative
    // ratio never exceeds the limit. The first ratio is checked before the second.
    logic       too_m;
    logic       too_n;
    logic [1:0] n_verdict;
    qdrf_pkg::t_quad_out r_out;

    always_comb begin
        too_m = res_m.den_zero || (!res_m.num_neg && (res_m.lhs > res_m.rhs));
        too_n = res_n.den_zero || (!res_n.num_neg && (res_n.lhs > res_n.rhs));
        if (r_dz7) begin
            n_verdict = qdrf_pkg::VERDICT_PARALLEL;
        end else if (too_m) begin
            n_verdict = qdrf_pkg::VERDICT_FIRST;
        end else if (too_n) begin
            n_verdict = qdrf_pkg::VERDICT_SECOND;
        end else begin
            n_verdict = qdrf_pkg::VERDICT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_out.verdict  <= n_verdict;
            r_out.accepted <= (n_verdict == qdrf_pkg::VERDICT_OK);
        end
    end

    assign o_out_data = r_out;

endmodule
